>>> src/mbc_pkg.sv
// Shared types, constants and helper functions for the mouse button chording block.
package mbc_pkg;

  localparam int WINDOW_BITS = 16;
  localparam int MAX_RES     = 5;
  localparam int CNT_W       = 3;
  localparam int CFG_W       = 16;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  typedef logic [2:0] btn_t;
  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t REG_BUTTON_COUNT  = 2'd0;
  localparam cfg_idx_t REG_CHORDING_MODE = 2'd1;
  localparam cfg_idx_t REG_WINDOW_TICKS  = 2'd2;

  localparam logic [1:0] MODE_DEFAULT = 2'd0;
  localparam logic [1:0] MODE_OFF     = 2'd1;
  localparam logic [1:0] MODE_ON      = 2'd2;

  localparam logic ACT_EVENT = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam logic [2:0]       BC_RESET   = 3'd3;
  localparam logic [1:0]       MODE_RESET = MODE_DEFAULT;
  localparam logic [CFG_W-1:0] WIN_RESET  = 16'd100;

  localparam btn_t BTN_MIN  = 3'd1;
  localparam btn_t BTN_MAX  = 3'd4;
  localparam btn_t VBTN_2   = 3'd2;
  localparam btn_t VBTN_3   = 3'd3;
  localparam btn_t VBTN_4   = 3'd4;
  localparam btn_t VBTN_5   = 3'd5;

  localparam logic [2:0] BC_TWO   = 3'd2;
  localparam logic [2:0] BC_THREE = 3'd3;
  localparam logic [2:0] BC_FOUR  = 3'd4;

  localparam logic [3:0] CHORD_12 = 4'b0011;
  localparam logic [3:0] CHORD_23 = 4'b0110;
  localparam logic [3:0] CHORD_13 = 4'b0101;

  localparam logic [32:0] WIN_MAX = (33'd1 << WINDOW_BITS) - 33'd1;

  typedef struct packed {
    logic [3:0] down;
    logic [3:0] ign;
    btn_t       saved;
    logic       sent;
  } chord_st_t;

  typedef struct packed {
    logic [CNT_W-1:0]       cnt;
    logic [MAX_RES-1:0][2:0] lb;
    logic [MAX_RES-1:0]     up;
  } plan_t;

  typedef struct packed {
    chord_st_t st;
    plan_t     plan;
  } work_t;

  function automatic logic [WINDOW_BITS-1:0] win_load(input logic [CFG_W-1:0] win);
    logic [32:0] w33;
    w33 = 33'(win);
    if (w33 > WIN_MAX) begin
      return WIN_MAX[WINDOW_BITS-1:0];
    end
    return w33[WINDOW_BITS-1:0];
  endfunction

  // Sends one virtual button through chord folding and the swap map.
  function automatic work_t mbc_put(input work_t w, input btn_t vb, input logic up,
                                    input logic [2:0] bc);
    work_t r;
    btn_t  v;
    btn_t  lb;
    logic  u;
    logic  drop;
    r    = w;
    v    = vb;
    u    = up;
    drop = 1'b0;
    lb   = vb;
    if (r.st.sent) begin
      if ((r.st.down & r.st.ign) != 4'd0) begin
        drop = 1'b1;
      end else if (r.st.ign != 4'd0) begin
        r.st.ign  = 4'd0;
        r.st.sent = 1'b0;
        v         = r.st.saved;
        u         = 1'b1;
      end
    end
    if (!drop) begin
      if (r.st.ign != 4'd0) begin
        r.st.sent = 1'b1;
      end
      if (v != 3'd0 && v <= VBTN_5) begin
        lb = v;
        if (bc == BC_TWO || bc == BC_FOUR) begin
          if (v == VBTN_2) begin
            lb = VBTN_3;
          end else if (v == VBTN_3) begin
            lb = VBTN_2;
          end
        end
        if (r.plan.cnt < CNT_W'(MAX_RES)) begin
          r.plan.lb[r.plan.cnt] = lb;
          r.plan.up[r.plan.cnt] = u;
          r.plan.cnt            = r.plan.cnt + 3'd1;
        end
      end
    end
    return r;
  endfunction

  // Releases every button that is down, the chord first.
  function automatic work_t mbc_release_all(input work_t w, input logic [2:0] bc);
    work_t r;
    r         = w;
    r.st.down = r.st.down & ~r.st.ign;
    if (r.st.ign != 4'd0) begin
      r = mbc_put(r, r.st.saved, 1'b1, bc);
    end
    for (int i = 0; i < 4; i++) begin
      if (r.st.down[i]) begin
        r = mbc_put(r, btn_t'(i + 1), 1'b1, bc);
      end
    end
    r.st.down = 4'd0;
    return r;
  endfunction

endpackage

>>> src/mbc_front.sv
// Front end: configuration registers, button state and classification of each request.
module mbc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_action,
  input  mbc_pkg::btn_t         in_button,
  input  logic                  in_is_release,
  input  logic                  q_full,
  output logic                  q_push,
  output mbc_pkg::plan_t        q_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  mbc_pkg::cfg_idx_t     cfg_index,
  input  logic [mbc_pkg::CFG_W-1:0] cfg_wdata
);
  import mbc_pkg::*;

  logic [2:0]             bc_r;
  logic [1:0]             mode_r;
  logic [CFG_W-1:0]       win_r;
  chord_st_t              st_r;
  logic                   held_v_r, held_v_nxt;
  btn_t                   held_b_r, held_b_nxt;
  logic [WINDOW_BITS-1:0] wc_r, wc_nxt;

  work_t      w;
  logic       accept;
  logic       bad;
  logic       chord_on;
  logic [3:0] bit_m;
  logic [3:0] cur_m;
  btn_t       cv;
  logic [3:0] ig;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !q_full;
  assign chord_on  = (bc_r == BC_TWO && mode_r != MODE_OFF) || mode_r == MODE_ON;

  always_comb begin
    w.st       = st_r;
    w.plan     = '0;
    held_v_nxt = held_v_r;
    held_b_nxt = held_b_r;
    wc_nxt     = wc_r;
    bit_m      = 4'b0001 << (in_button - 3'd1);
    bad        = in_is_release ? ((st_r.down & bit_m) == 4'd0)
                               : ((st_r.down & bit_m) != 4'd0);
    cur_m      = in_is_release ? (st_r.down & ~bit_m) : (st_r.down | bit_m);
    cv         = 3'd0;
    ig         = 4'd0;
    if (cur_m == CHORD_12 && bc_r == BC_TWO) begin
      cv = VBTN_3;
      ig = CHORD_12;
    end else if (cur_m == CHORD_12 && bc_r == BC_THREE) begin
      cv = VBTN_4;
      ig = CHORD_12;
    end else if (cur_m == CHORD_23 && bc_r == BC_THREE) begin
      cv = VBTN_5;
      ig = CHORD_23;
    end else if (cur_m == CHORD_13 && bc_r == BC_FOUR) begin
      cv = VBTN_5;
      ig = CHORD_13;
    end
    if (in_action == ACT_TICK) begin
      if (held_v_r) begin
        if (wc_r <= WINDOW_BITS'(1)) begin
          held_v_nxt = 1'b0;
          wc_nxt     = '0;
          w          = mbc_put(w, held_b_r, 1'b0, bc_r);
        end else begin
          wc_nxt = wc_r - WINDOW_BITS'(1);
        end
      end
    end else if (in_button >= BTN_MIN && in_button <= BTN_MAX) begin
      if (held_v_r) begin
        held_v_nxt = 1'b0;
        wc_nxt     = '0;
        if (bad) begin
          w = mbc_put(w, held_b_r, 1'b0, bc_r);
          w = mbc_release_all(w, bc_r);
        end else begin
          w.st.down = cur_m;
          if (cv != 3'd0) begin
            w.st.ign   = ig;
            w.st.saved = cv;
            w          = mbc_put(w, cv, 1'b0, bc_r);
          end else begin
            w = mbc_put(w, held_b_r, 1'b0, bc_r);
            w = mbc_put(w, in_button, in_is_release, bc_r);
          end
        end
      end else if (bad) begin
        w = mbc_release_all(w, bc_r);
      end else begin
        w.st.down = cur_m;
        if (st_r.down == 4'd0 && $onehot(cur_m) && chord_on) begin
          held_v_nxt = 1'b1;
          held_b_nxt = in_button;
          wc_nxt     = win_load(win_r);
        end else begin
          w = mbc_put(w, in_button, in_is_release, bc_r);
        end
      end
    end
  end

  assign q_push = accept && (w.plan.cnt != '0);
  assign q_data = w.plan;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r     <= BC_RESET;
      mode_r   <= MODE_RESET;
      win_r    <= WIN_RESET;
      st_r     <= '0;
      held_v_r <= 1'b0;
      held_b_r <= '0;
      wc_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BUTTON_COUNT:  bc_r   <= cfg_wdata[2:0];
          REG_CHORDING_MODE: mode_r <= cfg_wdata[1:0];
          REG_WINDOW_TICKS:  win_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        st_r     <= w.st;
        held_v_r <= held_v_nxt;
        held_b_r <= held_b_nxt;
        wc_r     <= wc_nxt;
      end
    end
  end

endmodule

>>> src/mbc_fifo.sv
// Short queue of result runs between the front end and the back end.
module mbc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mbc_pkg::plan_t wdata,
  output logic           full,
  input  logic           pop,
  output mbc_pkg::plan_t rdata,
  output logic           empty
);
  import mbc_pkg::*;

  plan_t                mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> src/mbc_back.sv
// Back end: unrolls each queued run into single results in an output register.
module mbc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  mbc_pkg::plan_t q_head,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic           out_pop,
  output logic           out_empty,
  output mbc_pkg::btn_t  out_logical_button,
  output logic           out_up,
  output logic           out_last
);
  import mbc_pkg::*;

  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  btn_t             lb_r;
  logic             up_r;
  logic             last_r;
  logic             load;
  logic             el_last;

  assign load    = !q_empty && (!out_valid_r || out_pop);
  assign el_last = (idx_r == q_head.cnt - 3'd1);
  assign q_pop   = load && el_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_pop;
    if (load) begin
      idx_nxt       = el_last ? '0 : idx_r + 3'd1;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lb_r   <= q_head.lb[idx_r];
      up_r   <= q_head.up[idx_r];
      last_r <= el_last;
    end
  end

  assign out_empty          = !out_valid_r;
  assign out_logical_button = lb_r;
  assign out_up             = up_r;
  assign out_last           = last_r;

endmodule

>>> src/mouse_button_chording.sv
// Top level of the mouse button chording block.
// Usage: button transitions and time ticks enter as requests on the input queue
// port (in_push while in_full is low). Each request produces zero to five results,
// read from the output queue port: a result is on out_* while out_empty is low and
// is taken with out_pop. out_last marks the final result of one request.
// Configuration is written on the cfg_ channel (always ready): index 0 button
// count, 1 chording mode, 2 window length in ticks; write only while idle.
// A request's results are registered in the queue, then in the output register.
// Throughput: one request per cycle when each causes at most one result and the
// receiver pops every result; results leave at one per cycle while out_pop is high,
// set by the single output register of the back end. A run leaves the queue with
// its last result. The front end classifies a request combinationally and queues
// its results as one run in a two-entry queue; in_full rises when that queue is
// full. When the receiver stalls, the current result holds, the queue fills and in_full
// rises; nothing is lost. Reset restores the default configuration (three buttons,
// default mode, window of 100 ticks), clears the button state and empties both queues.
module mouse_button_chording (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic                      in_action,
  input  mbc_pkg::btn_t             in_button,
  input  logic                      in_is_release,
  output logic                      out_empty,
  input  logic                      out_pop,
  output mbc_pkg::btn_t             out_logical_button,
  output logic                      out_up,
  output logic                      out_last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  mbc_pkg::cfg_idx_t         cfg_index,
  input  logic [mbc_pkg::CFG_W-1:0] cfg_wdata
);
  import mbc_pkg::*;

  plan_t q_wdata, q_rdata;
  logic  q_push, q_full, q_pop, q_empty;

  assign in_full = q_full;

  mbc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_action    (in_action),
    .in_button    (in_button),
    .in_is_release(in_is_release),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  mbc_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  mbc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_head            (q_rdata),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_logical_button(out_logical_button),
    .out_up            (out_up),
    .out_last          (out_last)
  );

endmodule

>>> src/mbc_checker.sv
// Port-level checks for the mouse button chording block, bound to its top level.
module mbc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [2:0] out_logical_button,
  input logic       out_up,
  input logic       out_last
);

  // Reset leaves both queues empty.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // Every delivered button number is between one and five.
  a_btn_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_logical_button != 3'd0) && (out_logical_button <= 3'd5))
    else $error("logical button out of range");

  // A result that is not taken stays in place.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_logical_button)
                               && $stable(out_up) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind mouse_button_chording mbc_checker u_mbc_checker (.*);
